// ----- src/gtr_pkg.sv -----
package gtr_pkg;

    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int SCALE_W    = 8;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    localparam int CNT_W      = $clog2(GLYPH_BITS);
    localparam int ROW_W      = $clog2(GLYPH_ROWS);
    localparam int ROM_DEPTH  = 96;
    localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] GLYPH_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] GLYPH_LAST  = 8'd127;
    localparam logic [CHAR_W-1:0] GLYPH_SUBST = 8'd63;

    localparam logic [COLOR_W-1:0] FG_RESET    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BG_RESET    = 24'h000000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;
    localparam logic [COORD_W-1:0] WIDTH_RESET = 16'd320;

    typedef enum logic [1:0] {
        REG_FG_COLOR   = 2'd0,
        REG_BACK_COLOR = 2'd1,
        REG_SCALE      = 2'd2,
        REG_WRAP_WIDTH = 2'd3
    } gtr_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } gtr_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] back_color;
        logic [SCALE_W-1:0] scale;
        logic [COORD_W-1:0] wrap_width;
    } gtr_cfg_t;

    typedef struct packed {
        logic accept_char;
        logic step;
        logic finish;
    } gtr_cmd_t;

    typedef struct packed {
        logic no_glyph;
        logic last_cmd;
    } gtr_stat_t;

    // Each entry holds the five column bytes with column 0 in the low byte.
    localparam logic [39:0] GLYPH_ROM [ROM_DEPTH] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
        40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
        40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040,
        40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
        40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
        40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h004428107F,
        40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
        40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
        40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
        40'h00007F0000, 40'h0008364100, 40'h081C2A0808, 40'h08082A1C08
    };

    function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0]    sel;
        logic [CHAR_W-1:0]    offs;
        logic [39:0]          entry;
        logic [GLYPH_BITS-1:0] bits;
        sel = code;
        if ((code < GLYPH_FIRST) || (code > GLYPH_LAST)) begin
            sel = GLYPH_SUBST;
        end
        offs  = sel - GLYPH_FIRST;
        entry = GLYPH_ROM[offs[ROM_IDX_W-1:0]];
        for (int c = 0; c < GLYPH_COLS; c++) begin
            bits[c*GLYPH_ROWS +: GLYPH_ROWS] = entry[c*8 +: GLYPH_ROWS];
        end
        return bits;
    endfunction

endpackage

// ----- src/gtr_regs.sv -----
module gtr_regs
    import gtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output gtr_cfg_t              cfg
);

    gtr_cfg_t cfg_reg;
    gtr_cfg_t cfg_next;
    gtr_reg_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = gtr_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_FG_COLOR:   cfg_next.fg_color   = pwdata[COLOR_W-1:0];
                REG_BACK_COLOR: cfg_next.back_color = pwdata[COLOR_W-1:0];
                REG_SCALE:      cfg_next.scale      = pwdata[SCALE_W-1:0];
                REG_WRAP_WIDTH: cfg_next.wrap_width = pwdata[COORD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_FG_COLOR:   prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, cfg_reg.fg_color};
            REG_BACK_COLOR: prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, cfg_reg.back_color};
            REG_SCALE:      prdata = {{(APB_DATA_W-SCALE_W){1'b0}}, cfg_reg.scale};
            REG_WRAP_WIDTH: prdata = {{(APB_DATA_W-COORD_W){1'b0}}, cfg_reg.wrap_width};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color   <= FG_RESET;
            cfg_reg.back_color <= BG_RESET;
            cfg_reg.scale      <= SCALE_RESET;
            cfg_reg.wrap_width <= WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/gtr_ctrl.sv -----
module gtr_ctrl
    import gtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    output logic      rect_valid,
    input  logic      rect_stall,
    input  gtr_stat_t stat,
    output gtr_cmd_t  cmd
);

    gtr_state_t state_reg;
    gtr_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (char_valid && !stat.no_glyph)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!rect_stall && stat.last_cmd)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        char_stall      = 1'b1;
        rect_valid      = 1'b0;
        cmd.accept_char = 1'b0;
        cmd.step        = 1'b0;
        cmd.finish      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                char_stall      = 1'b0;
                cmd.accept_char = char_valid;
            end
            ST_EMIT:
            begin
                rect_valid = 1'b1;
                cmd.step   = !rect_stall && !stat.last_cmd;
                cmd.finish = !rect_stall && stat.last_cmd;
            end
            default:
            begin
                char_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/gtr_dp.sv -----
module gtr_dp
    import gtr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  gtr_cfg_t           cfg,
    input  gtr_cmd_t           cmd,
    output gtr_stat_t          stat,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               string_start,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    output logic [COORD_W-1:0] rect_x0,
    output logic [COORD_W-1:0] rect_y0,
    output logic [COORD_W-1:0] rect_x1,
    output logic [COORD_W-1:0] rect_y1,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               last
);

    logic [COORD_W-1:0]    cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0]    cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0]    line_x_reg, line_x_next;
    logic [COORD_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic [GLYPH_BITS-1:0] glyph_reg, glyph_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    logic [COORD_W-1:0] cx_eff;
    logic [COORD_W-1:0] cy_eff;
    logic [COORD_W-1:0] lx_eff;
    logic [COORD_W-1:0] scale_ext;
    logic [COORD_W-1:0] line_pitch;
    logic [COORD_W-1:0] glyph_pitch;
    logic [COORD_W-1:0] advanced_x;
    logic [10:0]        glyph_width;
    logic signed [17:0] margin;
    logic               wrap;

    assign scale_ext   = {{(COORD_W-SCALE_W){1'b0}}, cfg.scale};
    assign line_pitch  = {{(COORD_W-SCALE_W-3){1'b0}}, cfg.scale, 3'b000};
    assign glyph_pitch = {{(COORD_W-SCALE_W-2){1'b0}}, cfg.scale, 2'b00}
                       + {{(COORD_W-SCALE_W-1){1'b0}}, cfg.scale, 1'b0};
    assign glyph_width = {1'b0, cfg.scale, 2'b00} + {3'b000, cfg.scale};
    assign margin      = $signed({2'b00, cfg.wrap_width}) - $signed({7'd0, glyph_width});
    assign advanced_x  = cursor_x_reg + glyph_pitch;
    assign wrap        = $signed({2'b00, advanced_x}) > margin;

    assign cx_eff = string_start ? start_x : cursor_x_reg;
    assign cy_eff = string_start ? start_y : cursor_y_reg;
    assign lx_eff = string_start ? start_x : line_x_reg;

    assign stat.no_glyph = (char_code == CHAR_NL) || (char_code == CHAR_CR);
    assign stat.last_cmd = (cnt_reg == CNT_W'(GLYPH_BITS - 1));

    assign rect_x0     = x_reg;
    assign rect_y0     = y_reg;
    assign rect_x1     = x_reg + scale_ext - 16'd1;
    assign rect_y1     = y_reg + scale_ext - 16'd1;
    assign pixel_color = glyph_reg[0] ? cfg.fg_color : cfg.back_color;
    assign last        = stat.last_cmd;

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_x_next   = line_x_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        glyph_next    = glyph_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        if (cmd.accept_char)
        begin
            line_x_next = lx_eff;
            if (char_code == CHAR_NL)
            begin
                cursor_x_next = lx_eff;
                cursor_y_next = cy_eff + line_pitch;
            end
            else if (char_code == CHAR_CR)
            begin
                cursor_x_next = lx_eff;
                cursor_y_next = cy_eff;
            end
            else
            begin
                cursor_x_next = cx_eff;
                cursor_y_next = cy_eff;
                x_next        = cx_eff;
                y_next        = cy_eff;
                glyph_next    = glyph_lookup(char_code);
                cnt_next      = '0;
                row_next      = '0;
            end
        end
        else if (cmd.step)
        begin
            glyph_next = glyph_reg >> 1;
            cnt_next   = cnt_reg + 1'b1;
            if (row_reg == ROW_W'(GLYPH_ROWS - 1))
            begin
                row_next = '0;
                y_next   = cursor_y_reg;
                x_next   = x_reg + scale_ext;
            end
            else
            begin
                row_next = row_reg + 1'b1;
                y_next   = y_reg + scale_ext;
            end
        end
        else if (cmd.finish)
        begin
            if (wrap)
            begin
                cursor_x_next = line_x_reg;
                cursor_y_next = cursor_y_reg + line_pitch;
            end
            else
            begin
                cursor_x_next = advanced_x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            line_x_reg   <= '0;
            cnt_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            line_x_reg   <= line_x_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        glyph_reg <= glyph_next;
    end

endmodule

// ----- src/glyph_text_rasterizer_top.sv -----
// Channel   Direction  Handshake               Payload
// char      in         char_valid/char_stall   char_code, string_start, start_x, start_y
// rect      out        rect_valid/rect_stall   rect_x0, rect_y0, rect_x1, rect_y1,
//                                              pixel_color, last
// config    in         APB psel/penable        fg_color, back_color, scale, wrap_width
//
// A printable character is accepted and read from the font table; then come 35
// commands, one per cycle while not stalled, from the command counter in the datapath.
// Newline and carriage return are taken without leaving idle and produce no command.
// Reset clears the cursor and line start and loads the register defaults.
// A stalled command holds, and the character input stays stalled until the
// last command of the glyph has been taken.
module glyph_text_rasterizer_top
    import gtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic                  string_start,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,
    output logic                  rect_valid,
    input  logic                  rect_stall,
    output logic [COORD_W-1:0]    rect_x0,
    output logic [COORD_W-1:0]    rect_y0,
    output logic [COORD_W-1:0]    rect_x1,
    output logic [COORD_W-1:0]    rect_y1,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last
);

    gtr_cfg_t  cfg;
    gtr_cmd_t  cmd;
    gtr_stat_t stat;

    gtr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .rect_valid (rect_valid),
        .rect_stall (rect_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    gtr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .char_code    (char_code),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .rect_x0      (rect_x0),
        .rect_y0      (rect_y0),
        .rect_x1      (rect_x1),
        .rect_y1      (rect_y1),
        .pixel_color  (pixel_color),
        .last         (last)
    );

    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        !(char_valid && !char_stall && rect_valid))
        else $error("Character accepted while commands are pending.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rect_valid && !rect_stall && last) |=> !rect_valid)
        else $error("Command issued after the last command of a glyph.");

    a_control_char_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && ((char_code == CHAR_NL) || (char_code == CHAR_CR)))
        |=> !rect_valid)
        else $error("Control character produced a command.");

    a_glyph_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rect_valid && !last) |=> rect_valid)
        else $error("Glyph ended before its last command.");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import gtr_pkg::*;

    localparam int RESET_CYCLES    = 5;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_REPORTS     = 40;
    localparam int NUM_DIRECTED    = 23;
    localparam int GLYPH_PITCH     = 6;
    localparam int LINE_PITCH      = 8;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COLOR_W-1:0] color;
        logic               last;
    } rect_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  code;
        logic               restart;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               typed;
        rect_cmd_t          first;
    } char_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // Five column bytes per glyph, column 0 in the top byte, row 0 in bit 0.
    localparam logic [39:0] FONT_COLS [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    // Where a row is typed, its first command is the expected one by hand.
    localparam char_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{8'd65,  1'b0, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1'b0}},
        '{8'd66,  1'b1, 16'd100,  16'd200,  1'b1,
          '{16'd100,  16'd200,  16'd100,  16'd200,  24'hFFFFFF, 1'b0}},
        '{CHAR_CR, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd33,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{CHAR_NL, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd32,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd127, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd0,   1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000000, 1'b0}},
        '{8'd255, 1'b1, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1'b0}},
        '{8'd31,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd128, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd9,   1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd11,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd12,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd14,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{CHAR_NL, 1'b1, 16'h8000, 16'h7FFF, 1'b0, '0},
        '{8'd87,  1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{CHAR_CR, 1'b1, 16'h5555, 16'hAAAA, 1'b0, '0},
        '{8'd126, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd77,  1'b1, 16'd315,  16'h0000, 1'b0, '0},
        '{8'd120, 1'b1, 16'd309,  16'hFFF8, 1'b0, '0},
        '{8'd121, 1'b0, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'd48,  1'b0, 16'h0000, 16'h0000, 1'b0, '0}
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  char_valid   = 1'b0;
    logic                  char_stall;
    logic [CHAR_W-1:0]     char_code    = '0;
    logic                  string_start = 1'b0;
    logic [COORD_W-1:0]    start_x      = '0;
    logic [COORD_W-1:0]    start_y      = '0;
    logic                  rect_valid;
    logic                  rect_stall   = 1'b0;
    logic [COORD_W-1:0]    rect_x0;
    logic [COORD_W-1:0]    rect_y0;
    logic [COORD_W-1:0]    rect_x1;
    logic [COORD_W-1:0]    rect_y1;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last;

    gtr_cfg_t           draw_cfg  = '{24'hFFFFFF, 24'h000000, 8'd1, 16'd320};
    logic [COORD_W-1:0] pen_x     = '0;
    logic [COORD_W-1:0] pen_y     = '0;
    logic [COORD_W-1:0] line_left = '0;

    rect_cmd_t   expected_rects [$];
    rect_cmd_t   want_rect;
    logic        first_typed    = 1'b0;
    rect_cmd_t   first_rect     = '0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          gap_max        = 1;
    stall_mode_t stall_mode     = STALL_NONE;
    int          stall_left     = 0;
    logic [2:0]  stall_phase    = '0;

    glyph_text_rasterizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .rect_valid   (rect_valid),
        .rect_stall   (rect_stall),
        .rect_x0      (rect_x0),
        .rect_y0      (rect_y0),
        .rect_x1      (rect_x1),
        .rect_y1      (rect_y1),
        .pixel_color  (pixel_color),
        .last         (last)
    );

    always #10 clk = ~clk;

    task automatic rasterize_char(input logic [CHAR_W-1:0] code, input logic restart,
                                  input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        logic [CHAR_W-1:0]  sel;
        logic [39:0]        cols;
        logic [7:0]         column;
        logic [COORD_W-1:0] step;
        rect_cmd_t          cmd;
        int                 right_margin;
        int                 pen_pos;
        step = {8'h00, draw_cfg.scale};
        if (restart)
        begin
            pen_x     = sx;
            line_left = sx;
            pen_y     = sy;
        end
        if (code == CHAR_NL)
        begin
            pen_x = line_left;
            pen_y = COORD_W'(pen_y + LINE_PITCH * step);
        end
        else if (code == CHAR_CR)
        begin
            pen_x = line_left;
        end
        else
        begin
            sel  = ((code < GLYPH_FIRST) || (code > GLYPH_LAST)) ? GLYPH_SUBST : code;
            cols = FONT_COLS[ROM_IDX_W'(sel - GLYPH_FIRST)];
            for (int c = 0; c < GLYPH_COLS; c++)
            begin
                column = cols[(GLYPH_COLS - 1 - c) * 8 +: 8];
                for (int r = 0; r < GLYPH_ROWS; r++)
                begin
                    cmd.x0    = COORD_W'(pen_x + c * step);
                    cmd.y0    = COORD_W'(pen_y + r * step);
                    cmd.x1    = COORD_W'(cmd.x0 + step - 1);
                    cmd.y1    = COORD_W'(cmd.y0 + step - 1);
                    cmd.color = column[r] ? draw_cfg.fg_color : draw_cfg.back_color;
                    cmd.last  = (c == GLYPH_COLS - 1) && (r == GLYPH_ROWS - 1);
                    expected_rects.push_back(cmd);
                end
            end
            pen_x        = COORD_W'(pen_x + GLYPH_PITCH * step);
            right_margin = int'(draw_cfg.wrap_width) - GLYPH_COLS * int'(step);
            pen_pos      = int'(pen_x);
            if (pen_pos > right_margin)
            begin
                pen_x = line_left;
                pen_y = COORD_W'(pen_y + LINE_PITCH * step);
            end
        end
    endtask

    task automatic write_register(input gtr_reg_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FG_COLOR:   draw_cfg.fg_color   = value[COLOR_W-1:0];
            REG_BACK_COLOR: draw_cfg.back_color = value[COLOR_W-1:0];
            REG_SCALE:      draw_cfg.scale      = value[SCALE_W-1:0];
            REG_WRAP_WIDTH: draw_cfg.wrap_width = value[COORD_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_request(input logic [CHAR_W-1:0] code, input logic restart,
                                input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        char_valid   <= 1'b1;
        char_code    <= code;
        string_start <= restart;
        start_x      <= sx;
        start_y      <= sy;
        do @(posedge clk); while (char_stall);
        rasterize_char(code, restart, sx, sy);
        if (first_typed)
        begin
            expected_rects[expected_rects.size() - GLYPH_BITS] = first_rect;
            first_typed = 1'b0;
        end
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            char_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic drain_rects();
        char_valid <= 1'b0;
        while (expected_rects.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [COLOR_W-1:0] want,
                                        input logic [COLOR_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rect_valid && !rect_stall)
        begin
            if (expected_rects.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: command expected none, got x0=%h y0=%h color=%h",
                             $time, rect_x0, rect_y0, pixel_color);
                end
            end
            else
            begin
                want_rect = expected_rects.pop_front();
                check_field("rect_x0", COLOR_W'(want_rect.x0), COLOR_W'(rect_x0));
                check_field("rect_y0", COLOR_W'(want_rect.y0), COLOR_W'(rect_y0));
                check_field("rect_x1", COLOR_W'(want_rect.x1), COLOR_W'(rect_x1));
                check_field("rect_y1", COLOR_W'(want_rect.y1), COLOR_W'(rect_y1));
                check_field("pixel_color", want_rect.color, pixel_color);
                check_field("last", COLOR_W'(want_rect.last), COLOR_W'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_left--;
        end
        stall_phase <= stall_phase + 3'd1;
        case (stall_mode)
            STALL_NONE:     rect_stall <= 1'b0;
            STALL_LIGHT:    rect_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rect_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rect_stall <= (stall_phase >= 3'd5);
            default:        rect_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [CHAR_W-1:0]     code;
        logic [APB_DATA_W-1:0] fg;
        logic [APB_DATA_W-1:0] bg;
        logic [SCALE_W-1:0]    sc;
        logic [COORD_W-1:0]    sw;
        char_row_t             row;
        int                    pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Phase 0 runs on the reset defaults; the rest sweep the registers.
            if (p > 0)
            begin
                fg = $urandom;
                bg = $urandom;
                sc = SCALE_W'($urandom_range(1, 255));
                sw = COORD_W'($urandom);
                case (p)
                    1:
                    begin
                        fg = 32'h000000;
                        bg = 32'hFFFFFF;
                        sc = 8'd255;
                        sw = 16'hFFFF;
                    end
                    2:
                    begin
                        sc = 8'd1;
                        sw = 16'd1;
                    end
                    3:
                    begin
                        sc = 8'd0;
                        sw = 16'd320;
                    end
                    4:
                    begin
                        sc = 8'd2;
                        sw = 16'd64;
                    end
                    5:
                    begin
                        sc = 8'd128;
                        sw = 16'h8000;
                    end
                    6:
                    begin
                        sc = 8'd1;
                        sw = 16'd5;
                    end
                    default: ;
                endcase
                write_register(REG_FG_COLOR, fg);
                write_register(REG_BACK_COLOR, bg);
                write_register(REG_SCALE, {24'h0, sc});
                write_register(REG_WRAP_WIDTH, {16'h0, sw});
            end
            gap_max = $urandom_range(1, 40);
            if (p == 0)
            begin
                for (int i = 0; i < NUM_DIRECTED; i++)
                begin
                    row         = DIRECTED_ROWS[i];
                    first_typed = row.typed;
                    first_rect  = row.first;
                    send_request(row.code, row.restart, row.sx, row.sy);
                end
            end
            send_request(CHAR_W'($urandom_range(GLYPH_FIRST, GLYPH_LAST)), 1'b1,
                         COORD_W'($urandom), COORD_W'($urandom));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    code = CHAR_W'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
                end
                else if (pick < 88)
                begin
                    code = CHAR_NL;
                end
                else if (pick < 93)
                begin
                    code = CHAR_CR;
                end
                else
                begin
                    code = CHAR_W'($urandom_range(0, 255));
                end
                send_request(code, $urandom_range(0, 11) == 0,
                             COORD_W'($urandom), COORD_W'($urandom));
            end
            drain_rects();
        end
        if (mismatch_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/gtr_pkg.sv
src/gtr_regs.sv
src/gtr_ctrl.sv
src/gtr_dp.sv
src/glyph_text_rasterizer_top.sv
bench/tb_top.sv
